// File: sv/ray_cube_intersection_assert.svh
// Assertion macros for the ray/cube intersection block.
// Used by the top level; depends on nothing else.
`ifndef RAY_CUBE_INTERSECTION_ASSERT_SVH
`define RAY_CUBE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define RCI_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define RCI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/rci_pkg.sv
// Shared types, constants and saturating helpers for the ray/cube block.
// No dependencies.
`default_nettype none

package rci_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 31;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [1:0]        nrm_t;

  localparam word_t WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  // 0.001 rounded to the nearest LSB, at least one LSB
  localparam int    EPS_CALC = ((1 << FRAC_W) + 500) / 1000;
  localparam word_t EPS_RAW  = (EPS_CALC > 0) ? WORD_W'(EPS_CALC) : WORD_W'(1);

  localparam nrm_t NRM_POS  = 2'sb01;
  localparam nrm_t NRM_NEG  = 2'sb11;
  localparam nrm_t NRM_ZERO = 2'sb00;

  typedef enum logic {
    CFG_BOX_HALF_SIZE = 1'b0,
    CFG_FAR_DISTANCE  = 1'b1
  } cfg_idx_e;

  // Per-ray status that rides along with the face-coordinate divide
  typedef struct packed {
    logic  hit;
    word_t dn;
    nrm_t  nx;
    nrm_t  ny;
    nrm_t  nz;
  } res_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? WMIN : WMAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic word_t s_neg(word_t a);
    if (a == WMIN) return WMAX;
    return -a;
  endfunction

  function automatic logic [WORD_W-1:0] mag(word_t a);
    return a[WORD_W-1] ? (~a + 1'b1) : a;
  endfunction

endpackage

`default_nettype wire

// File: sv/rci_div_bank.sv
// Pipelined signed fixed-point divider bank, restoring, one quotient bit per stage.
// Result is (num << FRAC_W) / den, truncated, saturated. Depends on rci_pkg.
`default_nettype none

module rci_div_bank #(
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire rci_pkg::word_t     num_i [LANES],
  input  wire rci_pkg::word_t     den_i [LANES],
  input  wire logic [SIDE_W-1:0]  side_i,
  output logic                    out_valid_o,
  output rci_pkg::word_t          quo_o [LANES],
  output logic [SIDE_W-1:0]       side_o
);

  localparam int W  = rci_pkg::WORD_W;
  localparam int QB = W - 1;              // quotient bits below saturation
  localparam int SH = QB - rci_pkg::FRAC_W;

  logic [W-1:0]     r_q   [QB+1][LANES];
  logic [QB-1:0]    nb_q  [QB+1][LANES];
  logic [W-1:0]     d_q   [QB+1][LANES];
  logic [QB-1:0]    q_q   [QB+1][LANES];
  logic [LANES-1:0] neg_q [QB+1];
  logic [LANES-1:0] ovf_q [QB+1];
  logic             vld_q [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];

  logic [W-1:0] nmag [LANES];
  logic [W-1:0] dmag [LANES];

  // Entry: magnitudes, overflow check, initial partial remainder
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nmag[l] = rci_pkg::mag(num_i[l]);
      dmag[l] = rci_pkg::mag(den_i[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int l = 0; l < LANES; l++) begin
      r_q[0][l]    <= W'(nmag[l] >> SH);
      nb_q[0][l]   <= {nmag[l][SH-1:0], {rci_pkg::FRAC_W{1'b0}}};
      d_q[0][l]    <= dmag[l];
      q_q[0][l]    <= '0;
      neg_q[0][l]  <= num_i[l][W-1] ^ den_i[l][W-1];
      ovf_q[0][l]  <= {{SH{1'b0}}, nmag[l]} >= {dmag[l], {SH{1'b0}}};
    end
  end

  // One restoring step per stage
  for (genvar k = 0; k < QB; k++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [W:0] rr;
      logic       ge;
      assign rr = {r_q[k][l], nb_q[k][l][QB-1]};
      assign ge = rr >= {1'b0, d_q[k][l]};
      always_ff @(posedge clk_i) begin
        r_q[k+1][l]   <= ge ? W'(rr - {1'b0, d_q[k][l]}) : rr[W-1:0];
        nb_q[k+1][l]  <= {nb_q[k][l][QB-2:0], 1'b0};
        d_q[k+1][l]   <= d_q[k][l];
        q_q[k+1][l]   <= {q_q[k][l][QB-2:0], ge};
        neg_q[k+1][l] <= neg_q[k][l];
        ovf_q[k+1][l] <= ovf_q[k][l];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      side_q[k+1] <= side_q[k];
    end
  end

  // Sign and saturation into the output register
  logic vld_out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_q[QB];
    for (int l = 0; l < LANES; l++) begin
      if (ovf_q[QB][l]) begin
        quo_o[l] <= neg_q[QB][l] ? rci_pkg::WMIN : rci_pkg::WMAX;
      end else begin
        quo_o[l] <= neg_q[QB][l] ? -{1'b0, q_q[QB][l]} : {1'b0, q_q[QB][l]};
      end
    end
  end

  assign out_valid_o = vld_out_q;

endmodule

`default_nettype wire

// File: sv/rci_slab.sv
// Slab combine pipeline: near/far distances, entry/exit, hit, normal and
// face sums. Depends on rci_pkg.
`default_nettype none

module rci_slab (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire rci_pkg::word_t v_i [3],
  input  wire rci_pkg::word_t w_i [3],
  input  wire rci_pkg::word_t d_i [3],
  output logic                out_valid_o,
  output rci_pkg::res_t       res_o,
  output rci_pkg::word_t      su_o,
  output rci_pkg::word_t      sv_o
);

  typedef rci_pkg::word_t word_t;

  logic [7:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:1], in_valid_i};
    end
  end

  // P1: far distance per axis
  word_t tp1_q [3], v1_q [3], d1_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tp1_q[i] <= rci_pkg::sat_add(w_i[i], rci_pkg::s_neg(v_i[i]));
      v1_q[i]  <= v_i[i];
      d1_q[i]  <= d_i[i];
    end
  end

  // P2: near distance per axis
  word_t tp2_q [3], tm2_q [3], v2_q [3], d2_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tm2_q[i] <= rci_pkg::sat_add(rci_pkg::s_neg(tp1_q[i]),
                    rci_pkg::s_neg(rci_pkg::sat_add(v1_q[i], v1_q[i])));
      tp2_q[i] <= tp1_q[i];
      v2_q[i]  <= v1_q[i];
      d2_q[i]  <= d1_q[i];
    end
  end

  // P3: entry = max near, exit = min far
  word_t dn_c, df_c;
  always_comb begin
    dn_c = tm2_q[0];
    df_c = tp2_q[0];
    for (int i = 1; i < 3; i++) begin
      if (tm2_q[i] > dn_c) dn_c = tm2_q[i];
      if (tp2_q[i] < df_c) df_c = tp2_q[i];
    end
  end

  word_t dn3_q, df3_q, tm3_q [3], v3_q [3], d3_q [3];
  always_ff @(posedge clk_i) begin
    dn3_q <= dn_c;
    df3_q <= df_c;
    for (int i = 0; i < 3; i++) begin
      tm3_q[i] <= tm2_q[i];
      v3_q[i]  <= v2_q[i];
      d3_q[i]  <= d2_q[i];
    end
  end

  // P4: hit test, normals, v + entry
  rci_pkg::res_t res4_q;
  word_t a4_q [3], d4_q [3];
  rci_pkg::nrm_t n_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (tm3_q[i] >= tm3_q[(i + 1) % 3] && tm3_q[i] >= tm3_q[(i + 2) % 3]) begin
        n_c[i] = (d3_q[i] > 0) ? rci_pkg::NRM_NEG : rci_pkg::NRM_POS;
      end else begin
        n_c[i] = rci_pkg::NRM_ZERO;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res4_q.hit <= (df3_q > 0) && (dn3_q < df3_q);
    res4_q.dn  <= dn3_q;
    res4_q.nx  <= n_c[0];
    res4_q.ny  <= n_c[1];
    res4_q.nz  <= n_c[2];
    for (int i = 0; i < 3; i++) begin
      a4_q[i] <= rci_pkg::sat_add(v3_q[i], dn3_q);
      d4_q[i] <= d3_q[i];
    end
  end

  // P5: magnitude product
  rci_pkg::res_t res5_q;
  logic [2*rci_pkg::WORD_W-1:0] p5_q [3];
  logic [2:0] sg5_q;
  always_ff @(posedge clk_i) begin
    res5_q <= res4_q;
    for (int i = 0; i < 3; i++) begin
      p5_q[i]  <= rci_pkg::mag(a4_q[i]) * rci_pkg::mag(d4_q[i]);
      sg5_q[i] <= a4_q[i][rci_pkg::WORD_W-1] ^ d4_q[i][rci_pkg::WORD_W-1];
    end
  end

  // P6: rescale product and saturate into u
  localparam int MW = 2 * rci_pkg::WORD_W - rci_pkg::FRAC_W;
  rci_pkg::res_t res6_q;
  word_t u6_q [3];
  logic [MW-1:0] m_c [3];
  logic [2:0] big_c;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c[i]   = p5_q[i][2*rci_pkg::WORD_W-1:rci_pkg::FRAC_W];
      big_c[i] = m_c[i] >= MW'(1) << (rci_pkg::WORD_W - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    res6_q <= res5_q;
    for (int i = 0; i < 3; i++) begin
      if (big_c[i]) begin
        u6_q[i] <= sg5_q[i] ? rci_pkg::WMIN : rci_pkg::WMAX;
      end else begin
        u6_q[i] <= sg5_q[i] ? -word_t'(m_c[i][rci_pkg::WORD_W-1:0])
                            : word_t'(m_c[i][rci_pkg::WORD_W-1:0]);
      end
    end
  end

  // Signed face-sum term: +u, -u or nothing, per the normal
  function automatic word_t acc(word_t s, rci_pkg::nrm_t n, word_t u);
    if (n == rci_pkg::NRM_POS) return rci_pkg::sat_add(s, u);
    if (n == rci_pkg::NRM_NEG) return rci_pkg::sat_add(s, rci_pkg::s_neg(u));
    return s;
  endfunction

  // P7: x and y normal terms
  rci_pkg::res_t res7_q;
  word_t su7_q, sv7_q, u7_q [3];
  always_ff @(posedge clk_i) begin
    res7_q <= res6_q;
    su7_q  <= acc(acc('0, res6_q.nx, u6_q[2]), res6_q.ny, u6_q[0]);
    sv7_q  <= acc(acc('0, res6_q.nx, u6_q[1]), res6_q.ny, u6_q[2]);
    for (int i = 0; i < 3; i++) u7_q[i] <= u6_q[i];
  end

  // P8: z normal term
  always_ff @(posedge clk_i) begin
    res_o <= res7_q;
    su_o  <= acc(su7_q, res7_q.nz, u7_q[1]);
    sv_o  <= acc(sv7_q, res7_q.nz, u7_q[0]);
  end

  logic vld8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld8_q <= 1'b0;
    end else begin
      vld8_q <= vld_q[7];
    end
  end

  assign out_valid_o = vld8_q;

endmodule

`default_nettype wire

// File: sv/ray_cube_intersection.sv
// Top level of the ray/cube slab intersection pipeline.
// Depends on rci_pkg, rci_div_bank, rci_slab and the assertion header.
`default_nettype none

`include "ray_cube_intersection_assert.svh"

// Ray against an origin-centered cube, fully pipelined: one ray may be started
// every cycle and busy is never raised. Each ray yields one result, shown for a
// single cycle with done_o, after passing the input register, two divider banks
// of one quotient bit per stage, the slab combine and the output register. The
// receiver cannot stall; results must be taken when done_o is high. Write the
// configuration only with no ray in flight.
module ray_cube_intersection (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [31:0]            origin_x_i,
  input  wire logic signed [31:0]            origin_y_i,
  input  wire logic signed [31:0]            origin_z_i,
  input  wire logic signed [31:0]            dir_x_i,
  input  wire logic signed [31:0]            dir_y_i,
  input  wire logic signed [31:0]            dir_z_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [rci_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic signed [31:0]                 distance_o,
  output logic signed [1:0]                  normal_x_o,
  output logic signed [1:0]                  normal_y_o,
  output logic signed [1:0]                  normal_z_o,
  output logic signed [31:0]                 face_u_o,
  output logic signed [31:0]                 face_v_o
);

  typedef rci_pkg::word_t word_t;
  localparam int W = rci_pkg::WORD_W;

  // Configuration registers
  logic [rci_pkg::CFG_W-1:0] box_q, far_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= rci_pkg::CFG_W'(65536);
      far_q <= rci_pkg::CFG_W'(1310720);
    end else if (cfg_we_i) begin
      case (rci_pkg::cfg_idx_e'(cfg_idx_i))
        rci_pkg::CFG_BOX_HALF_SIZE: box_q <= cfg_data_i;
        rci_pkg::CFG_FAR_DISTANCE:  far_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  word_t h;
  assign h    = (box_q == '0) ? word_t'(1) : word_t'({1'b0, box_q});
  assign busy = 1'b0;

  // Input register: zero direction becomes epsilon
  logic  vld0_q;
  word_t o0_q [3], d0_q [3], dm0_q [3];
  word_t o_in [3], d_in [3], dz [3];
  assign o_in = '{origin_x_i, origin_y_i, origin_z_i};
  assign d_in = '{dir_x_i, dir_y_i, dir_z_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dz[i] = (d_in[i] == '0) ? rci_pkg::EPS_RAW : d_in[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      o0_q[i]  <= o_in[i];
      d0_q[i]  <= dz[i];
      // |d| saturated to the word range
      dm0_q[i] <= (dz[i] == rci_pkg::WMIN) ? rci_pkg::WMAX : word_t'(rci_pkg::mag(dz[i]));
    end
  end

  // Divider bank A: v = o / d and h / |d|
  word_t numa [6], dena [6], quoa [6];
  logic  vlda;
  logic [3*W-1:0] sidea;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numa[i]     = o0_q[i];
      dena[i]     = d0_q[i];
      numa[i + 3] = h;
      dena[i + 3] = dm0_q[i];
    end
  end

  rci_div_bank #(.LANES(6), .SIDE_W(3 * W)) u_div_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld0_q),
    .num_i       (numa),
    .den_i       (dena),
    .side_i      ({d0_q[2], d0_q[1], d0_q[0]}),
    .out_valid_o (vlda),
    .quo_o       (quoa),
    .side_o      (sidea)
  );

  word_t va [3], wa [3], da [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = quoa[i];
      wa[i] = quoa[i + 3];
      da[i] = sidea[i*W +: W];
    end
  end

  // Slab combine
  logic          vlds;
  rci_pkg::res_t ress;
  word_t         su, sv;

  rci_slab u_slab (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vlda),
    .v_i         (va),
    .w_i         (wa),
    .d_i         (da),
    .out_valid_o (vlds),
    .res_o       (ress),
    .su_o        (su),
    .sv_o        (sv)
  );

  // Divider bank B: face coordinates over h
  word_t numb [2], denb [2], quob [2];
  logic  vldb;
  rci_pkg::res_t resb;
  assign numb = '{su, sv};
  assign denb = '{h, h};

  rci_div_bank #(.LANES(2), .SIDE_W($bits(rci_pkg::res_t))) u_div_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vlds),
    .num_i       (numb),
    .den_i       (denb),
    .side_i      (ress),
    .out_valid_o (vldb),
    .quo_o       (quob),
    .side_o      (resb)
  );

  // Output register: miss gives far distance and zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vldb;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o <= resb.hit;
    if (resb.hit) begin
      distance_o <= resb.dn;
      normal_x_o <= resb.nx;
      normal_y_o <= resb.ny;
      normal_z_o <= resb.nz;
      face_u_o   <= quob[0];
      face_v_o   <= quob[1];
    end else begin
      distance_o <= word_t'({1'b0, far_q});
      normal_x_o <= rci_pkg::NRM_ZERO;
      normal_y_o <= rci_pkg::NRM_ZERO;
      normal_z_o <= rci_pkg::NRM_ZERO;
      face_u_o   <= '0;
      face_v_o   <= '0;
    end
  end

  // Checks
  `RCI_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, done_o && !hit_o,
    normal_x_o == 2'sb00 && normal_y_o == 2'sb00 && normal_z_o == 2'sb00 &&
    face_u_o == '0 && face_v_o == '0, "miss result with nonzero normal or face")
  `RCI_ASSERT_NOW(a_hit_normal, clk_i, rst_ni, done_o && hit_o,
    normal_x_o != 2'sb00 || normal_y_o != 2'sb00 || normal_z_o != 2'sb00,
    "hit result without a face normal")
  `RCI_ASSERT_NOW(a_miss_far, clk_i, rst_ni, done_o && !hit_o,
    distance_o == word_t'({1'b0, far_q}), "miss distance differs from far distance")

endmodule

`default_nettype wire

// File: tb/ray_cube_intersection_tb.sv
// Self-checking testbench for the ray/cube slab intersection block.
// Depends on rci_pkg and ray_cube_intersection; holds its own slab-test predictor.
`timescale 1ns / 100ps

module ray_cube_intersection_tb;

  localparam int LATENCY   = 76;
  localparam int N_RANDOM  = 900;
  localparam int WDOG_MAX  = 2000;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] distance;
    logic signed [1:0]  nx, ny, nz;
    logic signed [31:0] fu, fv;
  } hit_rec_t;

  // Directed row: ray plus an optional typed-in expectation
  typedef struct {
    ray_t     ray;
    bit       fixed;
    hit_rec_t exp_rec;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [rci_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic done_o, hit_o;
  logic signed [31:0] distance_o, face_u_o, face_v_o;
  logic signed [1:0] normal_x_o, normal_y_o, normal_z_o;

  // Predictor copy of the configuration registers
  longint half_size_q = 65536;
  longint far_dist_q  = 1310720;

  hit_rec_t pending_q[$];
  int n_errors = 0;
  int wdog = 0;
  bit timed_out = 1'b0;

  ray_cube_intersection i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .hit_o, .distance_o, .normal_x_o, .normal_y_o, .normal_z_o,
    .face_u_o, .face_v_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------- fixed-point predictor (64-bit longint arithmetic) ----------------
  localparam longint W_HI = 64'sd2147483647;
  localparam longint W_LO = -64'sd2147483648;

  function automatic longint clip(longint x);
    return x > W_HI ? W_HI : (x < W_LO ? W_LO : x);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint fx_neg(longint a);
    return clip(-a);
  endfunction

  // Operands stay within 32 bits, so 64-bit products and shifted numerators are exact
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    p = p >>> rci_pkg::FRAC_W;
    return clip(neg ? -p : p);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    longint n, d, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n << rci_pkg::FRAC_W) / d;
    return clip(neg ? -q : q);
  endfunction

  function automatic hit_rec_t slab_predict(ray_t r);
    longint o[3], d[3], v[3], tp[3], tm[3], u[3], nrm[3];
    longint h, entry, leave, su, sv;
    hit_rec_t res;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    h = half_size_q == 0 ? 1 : half_size_q;
    for (int i = 0; i < 3; i++) begin
      if (d[i] == 0) d[i] = longint'(rci_pkg::EPS_RAW);
      v[i]  = fx_div(o[i], d[i]);
      tp[i] = fx_add(fx_div(h, clip(d[i] < 0 ? -d[i] : d[i])), fx_neg(v[i]));
      tm[i] = fx_add(fx_neg(tp[i]), fx_neg(fx_add(v[i], v[i])));
    end
    entry = tm[0];
    leave = tp[0];
    for (int i = 1; i < 3; i++) begin
      if (tm[i] > entry) entry = tm[i];
      if (tp[i] < leave) leave = tp[i];
    end
    res = '{hit: 1'b0, distance: 32'(far_dist_q), nx: rci_pkg::NRM_ZERO,
            ny: rci_pkg::NRM_ZERO, nz: rci_pkg::NRM_ZERO, fu: '0, fv: '0};
    if (!(leave > 0 && entry < leave)) return res;
    for (int i = 0; i < 3; i++) begin
      nrm[i] = (tm[i] >= tm[(i + 1) % 3] && tm[i] >= tm[(i + 2) % 3]) ?
               (d[i] > 0 ? -1 : 1) : 0;
      u[i] = fx_mul(fx_add(v[i], entry), d[i]);
    end
    su = 0;
    sv = 0;
    for (int i = 0; i < 3; i++) begin
      if (nrm[i] > 0) begin
        su = fx_add(su, u[(i + 2) % 3]);
        sv = fx_add(sv, u[(i + 1) % 3]);
      end else if (nrm[i] < 0) begin
        su = fx_add(su, fx_neg(u[(i + 2) % 3]));
        sv = fx_add(sv, fx_neg(u[(i + 1) % 3]));
      end
    end
    res.hit      = 1'b1;
    res.distance = 32'(entry);
    res.nx       = 2'(nrm[0]);
    res.ny       = 2'(nrm[1]);
    res.nz       = 2'(nrm[2]);
    res.fu       = 32'(fx_div(su, h));
    res.fv       = 32'(fx_div(sv, h));
    return res;
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      hit_rec_t e;
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result: hit %0b dist %0d", hit_o, distance_o);
      end else begin
        e = pending_q.pop_front();
        if (e.hit !== hit_o || e.distance !== distance_o || e.nx !== normal_x_o ||
            e.ny !== normal_y_o || e.nz !== normal_z_o || e.fu !== face_u_o ||
            e.fv !== face_v_o) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: exp hit %0b d %0d n %0d %0d %0d uv %0d %0d",
                      " | got hit %0b d %0d n %0d %0d %0d uv %0d %0d"},
                     e.hit, e.distance, e.nx, e.ny, e.nz, e.fu, e.fv, hit_o, distance_o,
                     normal_x_o, normal_y_o, normal_z_o, face_u_o, face_v_o);
        end
      end
    end
  end

  // Watchdog: cycles with neither an item accepted nor a result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- driving ----------------
  bit no_idle = 1'b0;

  task automatic send_ray(ray_t r, bit fixed = 1'b0, hit_rec_t fixed_rec = '{default: '0});
    while (!no_idle && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    origin_x_i <= r.ox;
    origin_y_i <= r.oy;
    origin_z_i <= r.oz;
    dir_x_i    <= r.dx;
    dir_y_i    <= r.dy;
    dir_z_i    <= r.dz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_q.push_back(fixed ? fixed_rec : slab_predict(r));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One write per call; the enable drops before the next write
  task automatic write_reg(rci_pkg::cfg_idx_e idx, longint value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= rci_pkg::CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rci_pkg::CFG_BOX_HALF_SIZE) half_size_q = value;
    else far_dist_q = value;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      2: return '0;
      3: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return 32'($signed($urandom_range(6 << 16)) - (3 << 16));
    endcase
  endfunction

  // Mostly rays aimed near the cube so hits dominate; the rest are arbitrary
  function automatic ray_t rnd_ray();
    ray_t r;
    r = '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()};
    if ($urandom_range(99) < 60) begin
      r.ox = 32'($signed($urandom_range(10 << 16)) - (5 << 16));
      r.oy = 32'($signed($urandom_range(10 << 16)) - (5 << 16));
      r.oz = 32'($signed($urandom_range(10 << 16)) - (5 << 16));
      r.dx = 32'(-(r.ox >>> 2) + $signed($urandom_range(1 << 15)) - (1 << 14));
      r.dy = 32'(-(r.oy >>> 2) + $signed($urandom_range(1 << 15)) - (1 << 14));
      r.dz = 32'(-(r.oz >>> 2) + $signed($urandom_range(1 << 15)) - (1 << 14));
    end
    return r;
  endfunction

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam hit_rec_t MISS_RESET = '{1'b0, 32'sd1310720, rci_pkg::NRM_ZERO,
                                      rci_pkg::NRM_ZERO, rci_pkg::NRM_ZERO, '0, '0};

  dir_row_t dir_table[] = '{
    // after reset: ray away from the cube misses with far distance 20.0
    '{'{3 * ONE, 0, 0, ONE, 0, 0}, 1'b1, MISS_RESET},
    '{'{0, 3 * ONE, 0, 0, ONE, 0}, 1'b1, MISS_RESET},
    // axis hits on both x faces, the -y face and the +z face
    '{'{-3 * ONE, 0, 0, ONE, 0, 0}, 1'b0, MISS_RESET},
    '{'{3 * ONE, 0, 0, -ONE, 0, 0}, 1'b0, MISS_RESET},
    '{'{0, -3 * ONE, 0, 0, ONE, 0}, 1'b0, MISS_RESET},
    '{'{0, 0, 3 * ONE, 0, 0, -ONE}, 1'b0, MISS_RESET},
    // zero direction everywhere
    '{'{0, 0, 0, 0, 0, 0}, 1'b0, MISS_RESET},
    // origin inside the cube
    '{'{ONE / 2, -ONE / 4, 0, ONE, ONE, ONE}, 1'b0, MISS_RESET},
    // diagonals: tie on all three axes, then on x and y
    '{'{-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE}, 1'b0, MISS_RESET},
    '{'{3 * ONE, -3 * ONE, 0, -ONE, ONE, 0}, 1'b0, MISS_RESET},
    // field extremes and saturation
    '{'{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1},
      1'b0, MISS_RESET},
    '{'{32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 1, 1}, 1'b0, MISS_RESET},
    '{'{-1, -1, -1, -1, -1, -1}, 1'b0, MISS_RESET},
    '{'{1, 1, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 1'b0, MISS_RESET},
    '{'{-2 * ONE, ONE / 2, ONE / 3, ONE, 0, 0}, 1'b0, MISS_RESET}
  };

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) send_ray(dir_table[i].ray, dir_table[i].fixed, dir_table[i].exp_rec);
    drain();

    // Register settings: extremes first, then a larger cube, random values and the reset values
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(rci_pkg::CFG_BOX_HALF_SIZE, 0);
          write_reg(rci_pkg::CFG_FAR_DISTANCE, 0);
        end
        1: begin
          write_reg(rci_pkg::CFG_BOX_HALF_SIZE, 1);
          write_reg(rci_pkg::CFG_FAR_DISTANCE, 2147483647);
        end
        2: begin
          write_reg(rci_pkg::CFG_BOX_HALF_SIZE, 2147483647);
          write_reg(rci_pkg::CFG_FAR_DISTANCE, 12345);
        end
        3: begin
          write_reg(rci_pkg::CFG_BOX_HALF_SIZE, 3 * 65536);
          write_reg(rci_pkg::CFG_FAR_DISTANCE, 1310720);
        end
        4: begin
          write_reg(rci_pkg::CFG_BOX_HALF_SIZE, $urandom_range(1 << 20, 1));
          write_reg(rci_pkg::CFG_FAR_DISTANCE, $urandom() & 32'h7FFFFFFF);
        end
        default: begin
          write_reg(rci_pkg::CFG_BOX_HALF_SIZE, 65536);
          write_reg(rci_pkg::CFG_FAR_DISTANCE, 1310720);
        end
      endcase
      no_idle = (phase == 3);
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        send_ray(rnd_ray());
        // sender waits out every expected result once
        if (phase == 5 && k == 40) drain();
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
